### sv/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion unit
`default_nettype none
package rmq_pkg;

  // default number of fraction bits of the matrix and quaternion elements
  localparam int FRAC_BITS_DEF = 14;

  // register indexes and reset values
  localparam int           REG_LENGTH_EPSILON = 0;
  localparam logic [14:0]  EPS_RESET          = 15'd1;

  // one input item: a 3x3 matrix, row r column c in mrc
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  // one result item: unit quaternion and the degenerate flag
  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               degenerate;
  } out_t;

endpackage
`default_nettype wire

### sv/rotation_matrix_to_quaternion_unit.sv
// rotation matrix to unit quaternion, fully pipelined
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | rmq_pkg::in_t, nine matrix elements
//   out_    | output    | out_valid/out_stall| rmq_pkg::out_t, quaternion and flag
//   cfg_    | input     | apb write/read     | length_epsilon at byte address 0
//
// one item enters per cycle while the pipeline is not held; the square root works
// one bit per stage (LW stages) and the divider one quotient bit per stage
// (FRAC_BITS + 1 stages)
// the pipeline moves as a whole: it holds while the output register is full and stalled
// reset (synchronous, active low) clears all valid bits and sets length_epsilon to 1
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire rmq_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output rmq_pkg::out_t     out_data,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // widths: signed unnormalized component, magnitude, square sum, length, remainder
  localparam int VW = ((FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18) + 1;
  localparam int MW = VW - 1;
  localparam int SW = 2 * MW + 2;
  localparam int LW = MW + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = LW + FRAC_BITS + 3;
  localparam int NV = LW + FRAC_BITS + 6;

  // axis codes for the largest diagonal element
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic signed [VW-1:0] ONE = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [15:0] ONE_SAT = (FRAC_BITS >= 15) ? 16'd32767 : 16'(1 << FRAC_BITS);

  logic en;
  logic [NV-1:0] vld_r;
  logic out_valid_r;
  rmq_pkg::out_t out_data_r, out_data_nxt;
  logic [14:0] eps_r;

  // stage one: unnormalized quaternion
  logic signed [VW-1:0] v_r [4];
  logic signed [VW-1:0] v_nxt [4];
  // stage two: magnitudes and signs; the stage after it: squares
  logic [MW-1:0] mg_r [4];
  logic [2*MW-1:0] sqr_r [4];
  logic [3:0] sg2_r;
  // square root stages
  logic [SW-1:0] rem_r [LW+1];
  logic [SW-1:0] rem_nxt [LW+1];
  logic [SW-1:0] root_r [LW+1];
  logic [SW-1:0] root_nxt [LW+1];
  logic [MW-1:0] smg_r [LW+2][4];
  logic [3:0] ssg_r [LW+2];
  // divider stages
  logic [RW-1:0] drem_r [FRAC_BITS+2][4];
  logic [RW-1:0] drem_nxt [FRAC_BITS+2][4];
  logic [QW-1:0] dq_r [FRAC_BITS+2][4];
  logic [QW-1:0] dq_nxt [FRAC_BITS+2][4];
  logic [LW-1:0] dlen_r [FRAC_BITS+2];
  logic [3:0] dsg_r [FRAC_BITS+2];

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'(rmq_pkg::REG_LENGTH_EPSILON)) ?
                      {17'd0, eps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rmq_pkg::EPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'(rmq_pkg::REG_LENGTH_EPSILON)) begin
      eps_r <= cfg_pwdata[14:0];
    end
  end

  // axis pick and unnormalized components
  always_comb begin
    logic [1:0] ax;
    logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    a00 = VW'(in_data.m00); a01 = VW'(in_data.m01); a02 = VW'(in_data.m02);
    a10 = VW'(in_data.m10); a11 = VW'(in_data.m11); a12 = VW'(in_data.m12);
    a20 = VW'(in_data.m20); a21 = VW'(in_data.m21); a22 = VW'(in_data.m22);
    ax = (in_data.m11 > in_data.m00) ? AX_Y : AX_X;
    if (ax == AX_Y) begin
      if (in_data.m22 > in_data.m11) ax = AX_Z;
    end else begin
      if (in_data.m22 > in_data.m00) ax = AX_Z;
    end
    case (ax)
      AX_Y: begin
        v_nxt[1] = a22 + a00 - a11 - ONE;
        v_nxt[2] = -(a12 + a21);
        v_nxt[0] = -(a10 + a01);
        v_nxt[3] = a20 - a02;
      end
      AX_Z: begin
        v_nxt[2] = a00 + a11 - a22 - ONE;
        v_nxt[0] = -(a20 + a02);
        v_nxt[1] = -(a21 + a12);
        v_nxt[3] = a01 - a10;
      end
      default: begin
        v_nxt[0] = a11 + a22 - a00 - ONE;
        v_nxt[1] = -(a01 + a10);
        v_nxt[2] = -(a02 + a20);
        v_nxt[3] = a12 - a21;
      end
    endcase
  end

  // square root, one result bit per stage; stage zero takes the square sum
  always_comb begin
    logic [SW-1:0] bitv;
    logic [SW:0] trial;
    rem_nxt[0]  = SW'(sqr_r[0]) + SW'(sqr_r[1]) + SW'(sqr_r[2]) + SW'(sqr_r[3]);
    root_nxt[0] = '0;
    for (int s = 0; s < LW; s++) begin
      bitv  = {{(SW-1){1'b0}}, 1'b1} << (2 * (LW - 1 - s));
      trial = {1'b0, root_r[s]} + {1'b0, bitv};
      if ({1'b0, rem_r[s]} >= trial) begin
        rem_nxt[s+1]  = rem_r[s] - trial[SW-1:0];
        root_nxt[s+1] = (root_r[s] >> 1) + bitv;
      end else begin
        rem_nxt[s+1]  = rem_r[s];
        root_nxt[s+1] = root_r[s] >> 1;
      end
    end
  end

  // restoring divider, one quotient bit per stage; stage zero loads the rounded numerator
  always_comb begin
    logic [RW-1:0] dsh;
    for (int l = 0; l < 4; l++) begin
      drem_nxt[0][l] = ({{(RW-MW){1'b0}}, smg_r[LW+1][l]} << (FRAC_BITS + 1))
                     + {{(RW-LW){1'b0}}, root_r[LW][LW-1:0]};
      dq_nxt[0][l]   = '0;
    end
    for (int t = 0; t <= FRAC_BITS; t++) begin
      dsh = {{(RW-LW-1){1'b0}}, dlen_r[t], 1'b0} << (FRAC_BITS - t);
      for (int l = 0; l < 4; l++) begin
        if (drem_r[t][l] >= dsh) begin
          drem_nxt[t+1][l] = drem_r[t][l] - dsh;
          dq_nxt[t+1][l]   = {dq_r[t][l][QW-2:0], 1'b1};
        end else begin
          drem_nxt[t+1][l] = drem_r[t][l];
          dq_nxt[t+1][l]   = {dq_r[t][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  // saturation and degenerate case
  always_comb begin
    logic [31:0] q32;
    logic [15:0] res [4];
    for (int l = 0; l < 4; l++) begin
      q32 = 32'(dq_r[FRAC_BITS+1][l]);
      if (dsg_r[FRAC_BITS+1][l]) begin
        if (q32 > 32'd32768) q32 = 32'd32768;
        res[l] = 16'(32'd0 - q32);
      end else begin
        if (q32 > 32'd32767) q32 = 32'd32767;
        res[l] = q32[15:0];
      end
    end
    if (32'(dlen_r[FRAC_BITS+1]) > 32'(eps_r)) begin
      out_data_nxt.quat_x     = res[0];
      out_data_nxt.quat_y     = res[1];
      out_data_nxt.quat_z     = res[2];
      out_data_nxt.quat_w     = res[3];
      out_data_nxt.degenerate = 1'b0;
    end else begin
      out_data_nxt.quat_x     = '0;
      out_data_nxt.quat_y     = '0;
      out_data_nxt.quat_z     = '0;
      out_data_nxt.quat_w     = ONE_SAT;
      out_data_nxt.degenerate = 1'b1;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        v_r[l]   <= v_nxt[l];
        mg_r[l]  <= v_r[l][VW-1] ? MW'(-v_r[l]) : MW'(v_r[l]);
        sg2_r[l] <= v_r[l][VW-1];
        sqr_r[l] <= (2*MW)'(mg_r[l]) * (2*MW)'(mg_r[l]);
        smg_r[0][l] <= mg_r[l];
      end
      ssg_r[0] <= sg2_r;
      for (int s = 0; s <= LW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
      for (int s = 0; s <= LW; s++) begin
        smg_r[s+1] <= smg_r[s];
        ssg_r[s+1] <= ssg_r[s];
      end
      dlen_r[0] <= root_r[LW][LW-1:0];
      dsg_r[0]  <= ssg_r[LW+1];
      for (int t = 0; t <= FRAC_BITS + 1; t++) begin
        drem_r[t] <= drem_nxt[t];
        dq_r[t]   <= dq_nxt[t];
      end
      for (int t = 0; t <= FRAC_BITS; t++) begin
        dlen_r[t+1] <= dlen_r[t];
        dsg_r[t+1]  <= dsg_r[t];
      end
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/rmq_checker.sv
// port-level checks for the rotation matrix to quaternion unit, with its bind
`default_nettype none
module rmq_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire rmq_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a degenerate result is the identity vector part
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.quat_x == 16'sd0 && out_data.quat_y == 16'sd0 && out_data.quat_z == 16'sd0)
    else $error("degenerate result with nonzero vector part");

  // input holds off only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
